/* design/dmx_command_parser_fader_assert.svh */
// assertion macros shared by the rtl
`ifndef DMX_COMMAND_PARSER_FADER_ASSERT_SVH
`define DMX_COMMAND_PARSER_FADER_ASSERT_SVH

// same-cycle implication, off during reset
`define DCPF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define DCPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dcpf_pkg.sv */
`timescale 1ns / 1ps

package dcpf_pkg;

    // input command codes
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // report kinds
    localparam logic [1:0] KIND_SET     = 2'd0;
    localparam logic [1:0] KIND_FADE    = 2'd1;
    localparam logic [1:0] KIND_INVALID = 2'd2;
    localparam logic [1:0] KIND_READ    = 2'd3;

    // characters
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_EOT   = 8'h04;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_F     = 8'h46;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // parse phases
    localparam logic [7:0] PH_START = 8'd0;
    localparam logic [7:0] PH_CHAN  = 8'd1;
    localparam logic [7:0] PH_VALUE = 8'd2;
    localparam logic [7:0] PH_DONE  = 8'd255;

    localparam logic [7:0] COUNT_MIN = 8'd2;
    localparam logic [7:0] COUNT_MAX = 8'd8;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [8:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  report_kind;
        logic [15:0] channel_number;
        logic [7:0]  command_value;
        logic [7:0]  level;
        logic [7:0]  target;
    } t_out_item;

endpackage

/* design/dcpf_channels.sv */
`timescale 1ns / 1ps

// input item channel
interface dcpf_in_if;
    logic              valid;
    logic              ready;
    dcpf_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// result item channel
interface dcpf_out_if;
    logic               valid;
    logic               ready;
    dcpf_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// configuration write channel
interface dcpf_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/dcpf_ram.sv */
`timescale 1ns / 1ps

module dcpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/dmx_command_parser_fader.sv */
// a command byte is taken in S_IDLE and parsed in S_BYTE, which makes its store write; a read
// passes S_IDLE, S_READ and S_RDATA; a fade tick walks the level store through one read and
// one write port; one transaction at a time, a byte held in S_BYTE while its result waits
// reset (synchronous, active low) clears the parser and starts a clearing pass over both
// stores, during which no input transaction is taken
`timescale 1ns / 1ps
`include "dmx_command_parser_fader_assert.svh"

module dmx_command_parser_fader #(
    parameter int CHANNELS = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dcpf_in_if.sink           i_in,
    dcpf_out_if.source        o_out,
    dcpf_cfg_if.sink          i_cfg
);

    localparam int AW = $clog2(CHANNELS);
    localparam int SW = AW + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_BYTE,
        S_READ,
        S_RDATA,
        S_FADE
    } t_state;

    // sequencer and transaction registers
    t_state              r_state, n_state;
    logic [SW-1:0]       r_step, n_step;
    dcpf_pkg::t_in_item  r_item, n_item;
    logic                r_out_valid, n_out_valid;
    dcpf_pkg::t_out_item r_out, n_out;
    logic                r_fade_allowed, n_fade_allowed;

    // parser state
    logic [7:0]  r_phase, n_phase;
    logic [7:0]  r_count, n_count;
    logic        r_fade_kind, n_fade_kind;
    logic [15:0] r_chan, n_chan;
    logic [7:0]  r_val, n_val;

    // parse of the held byte
    logic [7:0]  p_phase;
    logic [7:0]  p_count;
    logic        p_fade_kind;
    logic [15:0] p_chan;
    logic [7:0]  p_val;
    logic        p_submit;
    logic        is_digit;
    logic        is_sep;
    logic [7:0]  digit_val;

    // store ports
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic          lvl_we;
    logic          tgt_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    lvl_wdata;
    logic [7:0]    tgt_wdata;
    logic [7:0]    lvl_rdata;
    logic [7:0]    tgt_rdata;

    logic          out_free;
    logic          chan_ok;
    logic          read_ok;
    logic [SW-1:0] step_prev;
    logic [7:0]    lvl_stepped;

    dcpf_ram #(.WIDTH(8), .DEPTH(CHANNELS)) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (ram_waddr),
        .i_wdata (lvl_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (lvl_rdata)
    );

    dcpf_ram #(.WIDTH(8), .DEPTH(CHANNELS)) u_target_ram (
        .i_clk   (i_clk),
        .i_we    (tgt_we),
        .i_waddr (ram_waddr),
        .i_wdata (tgt_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (tgt_rdata)
    );

    // byte parser, one character per pass
    always_comb begin
        is_digit  = (r_item.data_byte >= dcpf_pkg::CHAR_ZERO)
                 && (r_item.data_byte <= dcpf_pkg::CHAR_NINE);
        is_sep    = (r_item.data_byte == dcpf_pkg::CHAR_SEMI)
                 || (r_item.data_byte == dcpf_pkg::CHAR_EOT)
                 || (r_item.data_byte == dcpf_pkg::CHAR_LF);
        digit_val = r_item.data_byte - dcpf_pkg::CHAR_ZERO;

        p_phase     = r_phase;
        p_count     = r_count + 8'd1;
        p_fade_kind = r_fade_kind;
        p_chan      = r_chan;
        p_val       = r_val;
        p_submit    = 1'b0;

        if (r_item.data_byte == dcpf_pkg::CHAR_COMMA) begin
            p_phase = r_phase + 8'd1;
        end else begin
            if (is_sep) begin
                p_phase = (p_count >= dcpf_pkg::COUNT_MIN) ? dcpf_pkg::PH_DONE
                                                           : dcpf_pkg::PH_START;
            end
            // overlong command restarts
            if (p_count > dcpf_pkg::COUNT_MAX) begin
                p_phase = dcpf_pkg::PH_START;
            end
            case (p_phase)
                dcpf_pkg::PH_START: begin
                    p_chan  = '0;
                    p_val   = '0;
                    p_count = '0;
                    if (r_item.data_byte == dcpf_pkg::CHAR_S) begin
                        p_phase     = dcpf_pkg::PH_CHAN;
                        p_fade_kind = 1'b0;
                    end else if (r_item.data_byte == dcpf_pkg::CHAR_F) begin
                        p_phase     = dcpf_pkg::PH_CHAN;
                        p_fade_kind = 1'b1;
                    end
                end
                dcpf_pkg::PH_CHAN: begin
                    if (is_digit) begin
                        p_chan = (r_chan << 3) + (r_chan << 1) + {8'd0, digit_val};
                    end
                end
                dcpf_pkg::PH_VALUE: begin
                    if (is_digit) begin
                        p_val = (r_val << 3) + (r_val << 1) + digit_val;
                    end
                end
                default: begin
                end
            endcase
            if (p_phase == dcpf_pkg::PH_DONE || r_item.last_byte) begin
                p_submit = 1'b1;
                p_phase  = dcpf_pkg::PH_START;
            end
        end
    end

    assign out_free    = !r_out_valid || o_out.ready;
    assign chan_ok     = (p_chan != 16'd0) && (p_chan <= 16'(CHANNELS));
    assign read_ok     = {1'b0, r_item.read_index} < 10'(CHANNELS);
    assign step_prev   = r_step - SW'(1);

    // one step of a level toward its target, shared over the whole fade walk
    assign lvl_stepped = (lvl_rdata > tgt_rdata) ? lvl_rdata - 8'd1 :
                         (lvl_rdata < tgt_rdata) ? lvl_rdata + 8'd1 : lvl_rdata;

    // sequencer
    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        n_item         = r_item;
        n_out_valid    = r_out_valid && !o_out.ready;
        n_out          = r_out;
        n_fade_allowed = r_fade_allowed;
        n_phase        = r_phase;
        n_count        = r_count;
        n_fade_kind    = r_fade_kind;
        n_chan         = r_chan;
        n_val          = r_val;

        ram_re    = 1'b0;
        ram_raddr = r_step[AW-1:0];
        lvl_we    = 1'b0;
        tgt_we    = 1'b0;
        ram_waddr = r_step[AW-1:0];
        lvl_wdata = '0;
        tgt_wdata = '0;

        i_in.ready = 1'b0;

        if (i_cfg.valid) begin
            n_fade_allowed = i_cfg.data;
        end

        case (r_state)
            S_CLEAR: begin
                lvl_we = 1'b1;
                tgt_we = 1'b1;
                n_step = r_step + SW'(1);
                if (r_step[AW-1:0] == AW'(CHANNELS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                i_in.ready = 1'b1;
                n_item     = i_in.data;
                n_step     = '0;
                if (i_in.valid) begin
                    case (i_in.data.cmd)
                        dcpf_pkg::CMD_BYTE: n_state = S_BYTE;
                        dcpf_pkg::CMD_TICK: n_state = S_FADE;
                        dcpf_pkg::CMD_READ: n_state = S_READ;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_BYTE: begin
                // a result waits for the output register to free up
                if (!p_submit || out_free) begin
                    n_state = S_IDLE;
                    if (r_item.last_byte) begin
                        n_phase     = '0;
                        n_count     = '0;
                        n_fade_kind = 1'b0;
                        n_chan      = '0;
                        n_val       = '0;
                    end else begin
                        n_phase     = p_phase;
                        n_count     = p_count;
                        n_fade_kind = p_fade_kind;
                        n_chan      = p_chan;
                        n_val       = p_val;
                    end
                    if (p_submit) begin
                        n_out_valid          = 1'b1;
                        n_out.channel_number = p_chan;
                        n_out.level          = '0;
                        n_out.target         = '0;
                        ram_waddr            = AW'(p_chan - 16'd1);
                        lvl_wdata            = p_val;
                        tgt_wdata            = p_val;
                        if (chan_ok) begin
                            tgt_we              = 1'b1;
                            n_out.command_value = p_val;
                            if (p_fade_kind && r_fade_allowed) begin
                                n_out.report_kind = dcpf_pkg::KIND_FADE;
                            end else begin
                                lvl_we            = 1'b1;
                                n_out.report_kind = dcpf_pkg::KIND_SET;
                            end
                        end else begin
                            n_out.report_kind   = dcpf_pkg::KIND_INVALID;
                            n_out.command_value = '0;
                        end
                    end
                end
            end
            S_READ: begin
                ram_re    = read_ok;
                ram_raddr = r_item.read_index[AW-1:0];
                n_state   = S_RDATA;
            end
            S_RDATA: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.report_kind    = dcpf_pkg::KIND_READ;
                    n_out.channel_number = {7'd0, r_item.read_index} + 16'd1;
                    n_out.command_value  = '0;
                    n_out.level          = read_ok ? lvl_rdata : 8'd0;
                    n_out.target         = read_ok ? tgt_rdata : 8'd0;
                    n_state              = S_IDLE;
                end
            end
            S_FADE: begin
                // read entry r_step while writing back entry r_step - 1
                ram_re    = (r_step < SW'(CHANNELS));
                ram_raddr = r_step[AW-1:0];
                lvl_we    = (r_step != '0);
                ram_waddr = step_prev[AW-1:0];
                lvl_wdata = lvl_stepped;
                n_step    = r_step + SW'(1);
                if (r_step == SW'(CHANNELS)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_step         <= '0;
            r_out_valid    <= 1'b0;
            r_fade_allowed <= 1'b0;
            r_phase        <= '0;
            r_count        <= '0;
            r_fade_kind    <= 1'b0;
            r_chan         <= '0;
            r_val          <= '0;
        end else begin
            r_state        <= n_state;
            r_step         <= n_step;
            r_out_valid    <= n_out_valid;
            r_fade_allowed <= n_fade_allowed;
            r_phase        <= n_phase;
            r_count        <= n_count;
            r_fade_kind    <= n_fade_kind;
            r_chan         <= n_chan;
            r_val          <= n_val;
        end
        r_item <= n_item;
        r_out  <= n_out;
    end

    // one transaction in flight at a time (an ignored code leaves the block idle)
    `DCPF_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in.valid && i_in.ready && (n_state != S_IDLE), !i_in.ready, "input taken while busy")
    // the fade walk never reads and writes one entry in the same cycle
    `DCPF_ASSERT_SAME(a_fade_no_clash, i_clk, i_rst_n, ram_re && lvl_we, ram_raddr != ram_waddr, "store read and write collide")
    // stores are only written while a transaction or the clearing pass runs
    `DCPF_ASSERT_SAME(a_write_busy, i_clk, i_rst_n, lvl_we || tgt_we, r_state != S_IDLE, "store written while idle")
    // a result held back keeps the parser where it is
    `DCPF_ASSERT_NEXT(a_byte_stall, i_clk, i_rst_n, (r_state == S_BYTE) && p_submit && !out_free, (r_state == S_BYTE) && $stable(r_phase), "stalled byte lost")

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_CHANNELS = 512;
    // the one command code with no package name: ignored by the block
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // cycles a fade tick may still be busy after the last report has come
    localparam int SETTLE_CYCLES = NUM_CHANNELS + 16;
    localparam int MAX_PRINTED = 200;

    // model of the lamp stores and the command parser, plus the reports still owed
    class dmx_lamp_model;
        bit [7:0]  level_mem [NUM_CHANNELS];
        bit [7:0]  target_mem [NUM_CHANNELS];
        bit [7:0]  parse_stage;
        bit [7:0]  char_seen;
        bit        is_fade;
        bit [15:0] chan_acc;
        bit [7:0]  value_acc;
        bit        fade_on;
        dcpf_pkg::t_out_item pending_reports[$];
        int        mismatches;

        function void clear_parser();
            parse_stage = dcpf_pkg::PH_START;
            char_seen   = '0;
            is_fade     = 1'b0;
            chan_acc    = '0;
            value_acc   = '0;
        endfunction

        // a completed command: store update and its report
        function void finish_command();
            dcpf_pkg::t_out_item r;
            r = '0;
            r.channel_number = chan_acc;
            if (chan_acc != 0 && chan_acc <= NUM_CHANNELS) begin
                target_mem[chan_acc - 16'd1] = value_acc;
                if (is_fade && fade_on) begin
                    r.report_kind = dcpf_pkg::KIND_FADE;
                end else begin
                    level_mem[chan_acc - 16'd1] = value_acc;
                    r.report_kind = dcpf_pkg::KIND_SET;
                end
                r.command_value = value_acc;
            end else begin
                r.report_kind = dcpf_pkg::KIND_INVALID;
            end
            pending_reports.push_back(r);
        endfunction

        function void take_char(input logic [7:0] c, input bit last_flag);
            bit is_digit;
            char_seen = char_seen + 8'd1;
            if (c == dcpf_pkg::CHAR_COMMA) begin
                parse_stage = parse_stage + 8'd1;
            end else begin
                is_digit = (c >= dcpf_pkg::CHAR_ZERO) && (c <= dcpf_pkg::CHAR_NINE);
                if (c == dcpf_pkg::CHAR_SEMI || c == dcpf_pkg::CHAR_EOT
                        || c == dcpf_pkg::CHAR_LF) begin
                    parse_stage = (char_seen >= dcpf_pkg::COUNT_MIN) ? dcpf_pkg::PH_DONE
                                                                     : dcpf_pkg::PH_START;
                end
                if (char_seen > dcpf_pkg::COUNT_MAX) begin
                    parse_stage = dcpf_pkg::PH_START;
                end
                case (parse_stage)
                    dcpf_pkg::PH_START: begin
                        chan_acc  = '0;
                        value_acc = '0;
                        char_seen = '0;
                        if (c == dcpf_pkg::CHAR_S) begin
                            is_fade     = 1'b0;
                            parse_stage = dcpf_pkg::PH_CHAN;
                        end else if (c == dcpf_pkg::CHAR_F) begin
                            is_fade     = 1'b1;
                            parse_stage = dcpf_pkg::PH_CHAN;
                        end
                    end
                    dcpf_pkg::PH_CHAN: begin
                        if (is_digit) begin
                            chan_acc = chan_acc * 16'd10 + {8'd0, c - dcpf_pkg::CHAR_ZERO};
                        end
                    end
                    dcpf_pkg::PH_VALUE: begin
                        if (is_digit) begin
                            value_acc = value_acc * 8'd10 + (c - dcpf_pkg::CHAR_ZERO);
                        end
                    end
                    default: ;
                endcase
                if (parse_stage == dcpf_pkg::PH_DONE || last_flag) begin
                    finish_command();
                    parse_stage = dcpf_pkg::PH_START;
                end
            end
            if (last_flag) clear_parser();
        endfunction

        function void note_item(input dcpf_pkg::t_in_item it);
            dcpf_pkg::t_out_item r;
            case (it.cmd)
                dcpf_pkg::CMD_BYTE: take_char(it.data_byte, it.last_byte);
                dcpf_pkg::CMD_TICK: begin
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        if (level_mem[i] > target_mem[i]) level_mem[i]--;
                        else if (level_mem[i] < target_mem[i]) level_mem[i]++;
                    end
                end
                dcpf_pkg::CMD_READ: begin
                    r = '0;
                    r.report_kind    = dcpf_pkg::KIND_READ;
                    r.channel_number = {7'd0, it.read_index} + 16'd1;
                    if (it.read_index < NUM_CHANNELS) begin
                        r.level  = level_mem[it.read_index];
                        r.target = target_mem[it.read_index];
                    end
                    pending_reports.push_back(r);
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(input string what);
            if (mismatches < MAX_PRINTED) $display("%0t mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
            if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_report(input dcpf_pkg::t_out_item got);
            dcpf_pkg::t_out_item want;
            if (pending_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected report kind %0d channel %0d",
                                          got.report_kind, got.channel_number));
            end else begin
                want = pending_reports.pop_front();
                compare_field("report_kind", 16'(got.report_kind), 16'(want.report_kind));
                compare_field("channel_number", got.channel_number, want.channel_number);
                compare_field("command_value", 16'(got.command_value),
                              16'(want.command_value));
                compare_field("level", 16'(got.level), 16'(want.level));
                compare_field("target", 16'(got.target), 16'(want.target));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    dcpf_in_if  in_ch ();
    dcpf_out_if out_ch ();
    dcpf_cfg_if cfg_ch ();

    dmx_lamp_model lamp_model = new;

    // idling switches, flipped now and then so that some stretches run flat out
    bit send_idle_on = 1'b1;
    bit take_idle_on = 1'b1;
    // a long receiver hold-off, asked for by the stimulus and served by the receiver
    int hold_cycles = 0;
    int items_sent = 0;

    dmx_command_parser_fader #(
        .CHANNELS (NUM_CHANNELS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // generous bound: several times the slowest run this stimulus can make
    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // everything is sampled at the rising edge, where all driven signals are settled
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            // results first: nothing accepted at this edge can already have a report out
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) lamp_model.check_report(out_ch.data);
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) lamp_model.note_item(in_ch.data);
            if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) lamp_model.fade_on = cfg_ch.data;
        end
    end

    function automatic int draw_wait(input bit enabled);
        return enabled ? $urandom_range(0, 14) : 0;
    endfunction

    function automatic dcpf_pkg::t_in_item make_item(input logic [1:0] kind,
                                                     input logic [7:0] c,
                                                     input logic last_flag,
                                                     input logic [8:0] idx);
        dcpf_pkg::t_in_item it;
        it.cmd        = kind;
        it.data_byte  = c;
        it.last_byte  = last_flag;
        it.read_index = idx;
        return it;
    endfunction

    // channel numbers cluster at both ends of the store so that reads find them again
    function automatic int pick_channel();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(NUM_CHANNELS + 1, 99999);
            2, 3:    return $urandom_range(NUM_CHANNELS - 15, NUM_CHANNELS);
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    // called and left at a falling edge; valid stays high when the next item follows at once
    task automatic send_item(input dcpf_pkg::t_in_item it);
        int gap;
        gap = draw_wait(send_idle_on);
        if (gap != 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.data  = it;
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_bytes(input byte unsigned seq[$], input int last_at);
        for (int i = 0; i < seq.size(); i++) begin
            send_item(make_item(dcpf_pkg::CMD_BYTE, seq[i], i == last_at,
                                9'($urandom_range(0, 511))));
        end
    endtask

    task automatic send_text(input string text, input bit mark_last);
        byte unsigned seq[$];
        for (int i = 0; i < text.len(); i++) seq.push_back(text[i]);
        send_bytes(seq, mark_last ? text.len() - 1 : -1);
    endtask

    task automatic send_read(input logic [8:0] idx);
        send_item(make_item(dcpf_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), idx));
    endtask

    task automatic send_tick();
        send_item(make_item(dcpf_pkg::CMD_TICK, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), 9'($urandom_range(0, 511))));
    endtask

    // one command with random content; a broken one is corrupted, cut or ended early
    task automatic send_command(input bit well_formed);
        byte unsigned seq[$];
        string        text;
        int           chan;
        int           value;
        int           last_at;
        int           pos;
        chan = pick_channel();
        case ($urandom_range(0, 5))
            0:       value = 255;
            1:       value = 0;
            2:       value = $urandom_range(256, 999);
            default: value = $urandom_range(0, 255);
        endcase
        text = $sformatf("%c%0d,%0d", $urandom_range(0, 1) ? dcpf_pkg::CHAR_S : dcpf_pkg::CHAR_F,
                         chan, value);
        // fade time field: parsed, never used, and often pushes the count over the limit
        if ($urandom_range(0, 9) == 0) text = {text, $sformatf(",%0d", $urandom_range(0, 9))};
        for (int i = 0; i < text.len(); i++) seq.push_back(text[i]);
        last_at = -1;
        case ($urandom_range(0, 3))
            0:       last_at = seq.size() - 1;
            1:       seq.push_back(dcpf_pkg::CHAR_SEMI);
            2:       seq.push_back(dcpf_pkg::CHAR_EOT);
            default: seq.push_back(dcpf_pkg::CHAR_LF);
        endcase
        if (!well_formed) begin
            pos = $urandom_range(0, seq.size() - 1);
            case ($urandom_range(0, 3))
                0: seq[pos] = 8'($urandom_range(0, 255));
                1: seq.insert(pos, dcpf_pkg::CHAR_COMMA);
                2: last_at = pos;
                default: begin
                    // the rest of the command never comes
                    while (seq.size() > pos + 1) void'(seq.pop_back());
                end
            endcase
        end
        send_bytes(seq, last_at);
    endtask

    // sender stops until every report is in, then lets a fade tick run out
    task automatic wait_quiet();
        in_ch.valid = 1'b0;
        while (lamp_model.pending_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_fade_allowed(input bit enable);
        wait_quiet();
        cfg_ch.data  = enable;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // receiver: random stalls per report, plus the one long hold-off on request
    initial begin
        int stall;
        int held;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_cycles != 0) begin
                held         = hold_cycles;
                hold_cycles  = 0;
                out_ch.ready = 1'b0;
                repeat (held) @(negedge i_clk);
            end
            stall = draw_wait(take_idle_on);
            if (stall != 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    initial begin
        int phase_end;
        int roll;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = 1'b0;
        i_rst_n      = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, fading not yet allowed: fade commands set the level at once
        write_fade_allowed(1'b0);
        send_text("S1,255;", 1'b0);                  // lowest channel, top value
        send_read(9'd0);
        send_text("F512,9", 1'b1);                   // highest channel, ended by the last byte
        send_read(9'd511);
        send_item(make_item(CMD_UNUSED, 8'hFF, 1'b1, 9'h1FF));   // ignored code, all ones
        send_tick();
        send_text("S;", 1'b0);                       // separator too early, no command
        send_item(make_item(dcpf_pkg::CMD_BYTE, dcpf_pkg::CHAR_COMMA, 1'b1, 9'd0));
                                                     // comma closing a packet

        // fading allowed: a fade command moves only the target, ticks walk the level
        write_fade_allowed(1'b1);
        send_text($sformatf("F9,4%c", dcpf_pkg::CHAR_EOT), 1'b0);
        send_read(9'd8);
        send_tick();
        send_read(9'd8);
        send_text($sformatf("S0%c", dcpf_pkg::CHAR_LF), 1'b0); // channel zero is invalid

        // random phases, each under its own fade setting
        for (int phase_no = 0; phase_no < 6; phase_no++) begin
            write_fade_allowed(phase_no % 2 == 1);
            send_idle_on = 1'($urandom_range(0, 1));
            take_idle_on = 1'($urandom_range(0, 1));
            if (phase_no == 1) begin
                // receiver holds off while reads keep coming: the block backs up
                send_idle_on = 1'b0;
                hold_cycles  = 400;
                repeat (40) send_read(9'($urandom_range(0, 511)));
            end
            phase_end = items_sent + 300;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 39) == 0) send_idle_on = !send_idle_on;
                if ($urandom_range(0, 39) == 0) take_idle_on = !take_idle_on;
                roll = $urandom_range(0, 99);
                if (roll < 55) begin
                    send_command(1'b1);
                end else if (roll < 63) begin
                    send_command(1'b0);
                end else if (roll < 83) begin
                    case ($urandom_range(0, 2))
                        0:       send_read(9'($urandom_range(0, 511)));
                        1:       send_read(9'($urandom_range(0, 11)));
                        default: send_read(9'($urandom_range(NUM_CHANNELS - 16,
                                                             NUM_CHANNELS - 1)));
                    endcase
                end else if (roll < 85) begin
                    send_tick();
                end else if (roll < 87) begin
                    send_item(make_item(CMD_UNUSED, 8'($urandom_range(0, 255)),
                                        1'($urandom_range(0, 1)),
                                        9'($urandom_range(0, 511))));
                end else begin
                    // stray byte, now and then closing the packet
                    send_item(make_item(dcpf_pkg::CMD_BYTE, 8'($urandom_range(0, 255)),
                                        $urandom_range(0, 7) == 0,
                                        9'($urandom_range(0, 511))));
                end
            end
        end

        wait_quiet();
        if (lamp_model.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
